/* sv/unsharp_mask_9x9_stream_macros.svh */
// Assertion macros shared by the RTL of the unsharp-mask block.
`ifndef UNSHARP_MASK_9X9_STREAM_MACROS_SVH
`define UNSHARP_MASK_9X9_STREAM_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define USM_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("usm assertion failed");

// Condition that must hold in the cycle after a trigger.
`define USM_ASSERT_NEXT(lbl, trig, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("usm assertion failed");

`endif

/* sv/usm_pkg.sv */
// Package with the types, weights and register codes of the unsharp-mask block.
`default_nettype none
package usm_pkg;

    // Register indexes on the configuration port.
    localparam logic REG_OUT_WIDTH  = 1'b0;
    localparam logic REG_OUT_HEIGHT = 1'b1;

    localparam int PAD_SIZE   = 8;
    localparam int HEIGHT_CAP = 2048;

    // Gaussian weights indexed by distance from the window centre.
    localparam logic [4:0] GAUSS_W [5][5] = '{
        '{5'd18, 5'd14, 5'd7, 5'd2, 5'd0},
        '{5'd14, 5'd11, 5'd5, 5'd1, 5'd0},
        '{5'd7,  5'd5,  5'd3, 5'd1, 5'd0},
        '{5'd2,  5'd1,  5'd1, 5'd0, 5'd0},
        '{5'd0,  5'd0,  5'd0, 5'd0, 5'd0}
    };

    function automatic int abs_off(input int i);
        return (i >= 4) ? (i - 4) : (4 - i);
    endfunction

    function automatic logic [4:0] gauss_weight(input int r, input int k);
        return GAUSS_W[abs_off(r)][abs_off(k)];
    endfunction

    // One slot of the restoring divider pipeline.
    typedef struct packed {
        logic        valid;
        logic        last;
        logic        sat;
        logic [7:0]  c;
        logic [7:0]  den;
        logic [12:0] rem;
        logic [7:0]  quo;
    } usm_div_t;

endpackage
`default_nettype wire

/* sv/unsharp_mask_9x9_stream.sv */
// Top level of the 9x9 unsharp-mask sharpener for a stream of grey pixels.
`default_nettype none
`include "unsharp_mask_9x9_stream_macros.svh"
// The block takes one 8-bit pixel per clock of a frame that is padded by
// four replicated pixels on every side, so each input row holds out_width+8
// pixels and a frame holds out_height+8 rows. Pixels in the first eight
// columns or rows of a frame only fill the line memory and the window and
// produce no output; every other pixel yields one sharpened pixel, in raster
// order, with tlast set on the last pixel of a frame. The pipeline accepts
// one item per clock whenever the output side is taking items. The
// thirteen register stages are the line memory read, the window, the row
// sums, the divider setup, the eight-stage divider and the output register,
// and a stall on the output holds all of them. The line memory is one
// single-port-per-direction array of MAX_WIDTH+8 words of eight pixels,
// read when a pixel enters and written back from stage 1 when the pipeline
// next advances. Its contents are undefined after reset and need no
// clearing pass. The size registers should only be changed between frames.
module unsharp_mask_9x9_stream
    import usm_pkg::*;
#(
    parameter int MAX_WIDTH = 1920
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Input stream.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] pixel_in
    // Output stream.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // [7:0] pixel_out
    output logic             m_tlast,   // frame_last
    // Configuration port.
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int LINE_LEN = MAX_WIDTH + PAD_SIZE;
    localparam int CW       = $clog2(LINE_LEN);
    localparam int WW       = (CW + 1 > 12) ? CW + 1 : 12;

    // Configuration registers.
    logic [10:0] out_width_reg;
    logic [11:0] out_height_reg;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_width_reg  <= 11'd1920;
            out_height_reg <= 12'd1080;
        end
        else if (psel && penable && pwrite && pready)
        begin
            unique case (paddr[2])
                REG_OUT_WIDTH:  out_width_reg  <= pwdata[10:0];
                REG_OUT_HEIGHT: out_height_reg <= pwdata[11:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_OUT_WIDTH:  prdata = {21'd0, out_width_reg};
            REG_OUT_HEIGHT: prdata = {20'd0, out_height_reg};
            default:        prdata = '0;
        endcase
    end

    // The whole pipeline moves when the output register can take a value.
    logic adv;
    logic s_accept;
    logic out_valid_reg;

    assign adv      = !out_valid_reg || m_tready;
    assign s_tready = adv;
    assign s_accept = s_tvalid && s_tready;

    // Effective frame size after clamping the registers.
    logic [WW-1:0] eff_w;
    logic [WW-1:0] in_w;
    logic [11:0]   eff_h;
    logic [11:0]   in_h;

    always_comb
    begin
        if (out_width_reg == 11'd0)
        begin
            eff_w = WW'(1);
        end
        else if (WW'(out_width_reg) > WW'(MAX_WIDTH))
        begin
            eff_w = WW'(MAX_WIDTH);
        end
        else
        begin
            eff_w = WW'(out_width_reg);
        end
        if (out_height_reg == 12'd0)
        begin
            eff_h = 12'd1;
        end
        else if (out_height_reg > 12'(HEIGHT_CAP))
        begin
            eff_h = 12'(HEIGHT_CAP);
        end
        else
        begin
            eff_h = out_height_reg;
        end
        in_w = eff_w + WW'(PAD_SIZE);
        in_h = eff_h + 12'(PAD_SIZE);
    end

    // Column and row position of the next input pixel.
    logic [CW-1:0] col_reg, col_next;
    logic [11:0]   row_reg, row_next;
    logic [WW-1:0] col_w;
    logic          row_end;
    logic          emit;
    logic          frame_end;

    always_comb
    begin
        col_w     = WW'(col_reg);
        row_end   = (col_w + WW'(1) >= in_w);
        emit      = (col_w >= WW'(PAD_SIZE)) && (row_reg >= 12'(PAD_SIZE))
                    && (col_w < in_w) && (row_reg < in_h);
        frame_end = (col_w == in_w - WW'(1)) && (row_reg == in_h - 12'd1);
        col_next  = col_reg;
        row_next  = row_reg;
        if (row_end)
        begin
            col_next = '0;
            row_next = (row_reg + 12'd1 >= in_h) ? 12'd0 : row_reg + 12'd1;
        end
        else
        begin
            col_next = col_reg + CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (s_accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // Stage 1: line memory read data and the pixel that came with it.
    logic [63:0]   line_mem [LINE_LEN];
    logic [63:0]   rd_reg;
    logic          s1_valid_reg;
    logic          s1_emit_reg;
    logic          s1_last_reg;
    logic [CW-1:0] s1_col_reg;
    logic [7:0]    s1_pix_reg;

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            rd_reg <= line_mem[col_reg];
        end
        if (adv && s1_valid_reg)
        begin
            // Each line moves up by one and the new pixel becomes the newest line.
            line_mem[s1_col_reg] <= {s1_pix_reg, rd_reg[63:8]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_emit_reg  <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= s_accept;
            s1_emit_reg  <= s_accept && emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_last_reg <= frame_end;
            s1_col_reg  <= col_reg;
            s1_pix_reg  <= s_tdata;
        end
    end

    // Stage 2: the 9x9 window shifts left and takes the new column.
    logic [7:0] win_reg [9][9];
    logic       s2_valid_reg;
    logic       s2_last_reg;

    always_ff @(posedge clk)
    begin
        if (adv && s1_valid_reg)
        begin
            for (int r = 0; r < 9; r++)
            begin
                for (int k = 0; k < 8; k++)
                begin
                    win_reg[r][k] <= win_reg[r][k + 1];
                end
            end
            for (int r = 0; r < 8; r++)
            begin
                win_reg[r][8] <= rd_reg[8 * r +: 8];
            end
            win_reg[8][8] <= s1_pix_reg;
        end
        if (adv)
        begin
            s2_last_reg <= s1_last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s2_valid_reg <= s1_emit_reg;
        end
    end

    // Stage 3: weighted sum of each window row.
    logic [15:0] row_sum_next [9];
    logic [15:0] row_sum_reg  [9];
    logic        s3_valid_reg;
    logic        s3_last_reg;
    logic [7:0]  s3_c_reg;

    always_comb
    begin
        for (int r = 0; r < 9; r++)
        begin
            row_sum_next[r] = '0;
            for (int k = 0; k < 9; k++)
            begin
                row_sum_next[r] = row_sum_next[r]
                                  + 16'(win_reg[r][k]) * 16'(gauss_weight(r, k));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            row_sum_reg <= row_sum_next;
            s3_last_reg <= s2_last_reg;
            s3_c_reg    <= win_reg[4][4];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    // Stage 4: blur, clamped sharpen value and divider setup.
    logic [15:0] total;
    logic [7:0]  blur;
    logic [8:0]  two_c;
    logic [8:0]  sharp_raw;
    logic [7:0]  sharp;
    logic [7:0]  den;
    usm_div_t    div_next;
    usm_div_t    div_in_reg;
    usm_div_t    div_out;

    always_comb
    begin
        total = '0;
        for (int r = 0; r < 9; r++)
        begin
            total = total + row_sum_reg[r];
        end
        blur      = total[15:8];
        two_c     = {s3_c_reg, 1'b0};
        sharp_raw = (two_c > 9'(blur)) ? two_c - 9'(blur) : 9'd0;
        sharp     = sharp_raw[8] ? 8'd255 : sharp_raw[7:0];
        den       = (s3_c_reg == 8'd0) ? 8'd1 : s3_c_reg;
        div_next.valid = s3_valid_reg;
        div_next.last  = s3_last_reg;
        // The quotient saturates when sharp*32 reaches 256*den.
        div_next.sat   = ({3'b000, sharp} >= {den, 3'b000});
        div_next.c     = s3_c_reg;
        div_next.den   = den;
        div_next.rem   = {sharp, 5'b00000};
        div_next.quo   = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_in_reg <= '0;
        end
        else if (adv)
        begin
            div_in_reg <= div_next;
        end
    end

    usm_div u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .adv  (adv),
        .din  (div_in_reg),
        .dout (div_out)
    );

    // Final stage: scale the ratio back by the centre pixel.
    logic [7:0]  ratio;
    logic [15:0] prod;
    logic [7:0]  pix_final;
    logic [7:0]  out_pix_reg;
    logic        out_last_reg;

    always_comb
    begin
        ratio     = div_out.sat ? 8'd255 : div_out.quo;
        prod      = 16'(ratio) * 16'(div_out.c);
        pix_final = (prod[15:13] != 3'b000) ? 8'd255 : prod[12:5];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= div_out.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_pix_reg  <= pix_final;
            out_last_reg <= div_out.last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_pix_reg;
    assign m_tlast  = out_last_reg;

    // The column count never leaves the line memory.
    `USM_ASSERT(col_in_range_a, WW'(col_reg) < WW'(LINE_LEN))
    // The row count stays below the tallest padded frame.
    `USM_ASSERT(row_in_range_a, row_reg < 12'(HEIGHT_CAP + PAD_SIZE))
    // The last pixel of a row returns the column count to zero.
    `USM_ASSERT_NEXT(col_wrap_a, s_accept && row_end, col_reg == '0)
    // An empty output register never blocks the input.
    `USM_ASSERT(ready_when_empty_a, !out_valid_reg |-> s_tready)

endmodule
`default_nettype wire

/* sv/usm_div.sv */
// Eight-stage restoring divider producing one quotient bit per stage.
`default_nettype none
module usm_div
    import usm_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     adv,
    input  wire usm_div_t din,
    output usm_div_t      dout
);

    usm_div_t stage_reg  [8];
    usm_div_t stage_next [8];

    always_comb
    begin
        usm_div_t   prev;
        logic [15:0] trial;
        for (int i = 0; i < 8; i++)
        begin
            prev  = (i == 0) ? din : stage_reg[(i == 0) ? 0 : i - 1];
            trial = 16'(prev.den) << (7 - i);
            stage_next[i] = prev;
            if ({3'b000, prev.rem} >= trial)
            begin
                stage_next[i].rem        = 13'({3'b000, prev.rem} - trial);
                stage_next[i].quo[7 - i] = 1'b1;
            end
            else
            begin
                stage_next[i].quo[7 - i] = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
            begin
                stage_reg[i] <= '0;
            end
        end
        else if (adv)
        begin
            for (int i = 0; i < 8; i++)
            begin
                stage_reg[i] <= stage_next[i];
            end
        end
    end

    assign dout = stage_reg[7];

endmodule
`default_nettype wire

/* tb/sv/unsharp_mask_9x9_stream_tb.sv */
// Self-checking testbench for the 9x9 unsharp-mask stream sharpener.
`default_nettype none
// The testbench sends whole padded frames of grey pixels through the block.
// Frame sizes are set on the configuration port between frames.
// An internal model follows every accepted pixel through its own line stores
// and its own 9x9 window. It queues the sharpened pixel that the block should
// give back, and the monitor checks every output item against that queue.
// Frames are small, and a few use the degenerate register values.
// Both stream sides idle at random, in changing proportions.
module unsharp_mask_9x9_stream_tb
    import usm_pkg::*;
;

    localparam int LINE_W    = 1920 + 8;
    localparam int WDOG_MAX  = 20000;
    localparam int HOLD_LEN  = 3000;
    localparam int DRAIN_CYC = 50;

    typedef enum int {PAT_RANDOM, PAT_EXTREME, PAT_CHECKER, PAT_FLAT_LO, PAT_FLAT_HI} pattern_t;

    typedef struct packed {
        logic [7:0] pixel;
        logic       last;
    } sharp_pix_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'd0;      // [7:0] pixel_in
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;             // [7:0] pixel_out
    logic        m_tlast;             // frame_last
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = 3'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    unsharp_mask_9x9_stream DUT (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #5 clk = ~clk;

    // Pixels waiting to be offered, and sharpened pixels still owed by the block.
    logic [7:0]  pixel_pending [$];
    sharp_pix_t  sharp_owed [$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_requests = 0;
    int hold_served = 0;
    int hold_left = 0;
    int mismatches = 0;
    int pixels_sent = 0;
    int results_seen = 0;
    int frames_run = 0;
    int wdog = 0;

    // Mirror of the configuration and of the block's state.
    logic [10:0] mir_width = 11'd1920;
    logic [11:0] mir_height = 12'd1080;
    logic [7:0]  mir_lines [8][LINE_W];
    logic [7:0]  mir_win [9][9];
    int          mir_col = 0;
    int          mir_row = 0;

    // Gaussian weights by distance from the centre row and column.
    int gauss [5][5] = '{
        '{18, 14, 7, 2, 0},
        '{14, 11, 5, 1, 0},
        '{7, 5, 3, 1, 0},
        '{2, 1, 1, 0, 0},
        '{0, 0, 0, 0, 0}
    };

    function automatic int dist4(input int i);
        return (i >= 4) ? i - 4 : 4 - i;
    endfunction

    function automatic int eff_width();
        int ew;
        ew = mir_width;
        if (ew == 0) ew = 1;
        if (ew > 1920) ew = 1920;
        return ew;
    endfunction

    function automatic int eff_height();
        int eh;
        eh = mir_height;
        if (eh == 0) eh = 1;
        if (eh > HEIGHT_CAP) eh = HEIGHT_CAP;
        return eh;
    endfunction

    // Sharpened value of the current window centre.
    function automatic logic [7:0] sharpen_centre();
        int acc, blur, c, s, q, o, den;
        acc = 0;
        for (int r = 0; r < 9; r++)
            for (int k = 0; k < 9; k++)
                acc += mir_win[r][k] * gauss[dist4(r)][dist4(k)];
        blur = (acc >> 8) & 255;
        c = mir_win[4][4];
        // A negative difference clamps to zero.
        s = (2 * c > blur) ? 2 * c - blur : 0;
        if (s > 255) s = 255;
        den = (c == 0) ? 1 : c;
        q = (s * 32) / den;
        if (q > 255) q = 255;
        o = (q * c) / 32;
        if (o > 255) o = 255;
        return o[7:0];
    endfunction

    // Advance the mirror by one accepted pixel and queue its result, if any.
    task automatic track_pixel(input logic [7:0] p);
        logic [7:0] column [9];
        int w, h;
        sharp_pix_t res;
        w = eff_width() + PAD_SIZE;
        h = eff_height() + PAD_SIZE;
        if (mir_col < LINE_W) begin
            for (int r = 0; r < 8; r++) column[r] = mir_lines[r][mir_col];
            column[8] = p;
            for (int r = 0; r < 7; r++) mir_lines[r][mir_col] = mir_lines[r + 1][mir_col];
            mir_lines[7][mir_col] = p;
            for (int r = 0; r < 9; r++) begin
                for (int k = 0; k < 8; k++) mir_win[r][k] = mir_win[r][k + 1];
                mir_win[r][8] = column[r];
            end
            if (mir_col >= PAD_SIZE && mir_row >= PAD_SIZE && mir_col < w && mir_row < h) begin
                res.pixel = sharpen_centre();
                res.last = (mir_col == w - 1 && mir_row == h - 1);
                sharp_owed.push_back(res);
            end
        end
        if (mir_col + 1 >= w) begin
            mir_col = 0;
            mir_row = (mir_row + 1 >= h) ? 0 : mir_row + 1;
        end else begin
            mir_col = mir_col + 1;
        end
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        if (mismatches <= 20)
            $display("mismatch at result %0d: %s got %0d want %0d", results_seen, what, got, want);
    endtask

    // Sender: one nonblocking update of valid and data per clock while no offered pixel is waiting.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (s_tvalid && s_tready) begin
                track_pixel(s_tdata);
                pixels_sent++;
            end
            if (!s_tvalid || s_tready) begin
                if (pixel_pending.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_tdata <= pixel_pending.pop_front();
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks each output item and decides the next ready.
    always @(posedge clk)
    begin
        sharp_pix_t want;
        if (rst_n) begin
            if (m_tvalid && m_tready) begin
                if (sharp_owed.size() == 0) begin
                    report_mismatch("unexpected item, pixel", m_tdata, -1);
                end else begin
                    want = sharp_owed.pop_front();
                    if (m_tdata !== want.pixel) report_mismatch("pixel_out", m_tdata, want.pixel);
                    if (m_tlast !== want.last) report_mismatch("frame_last", m_tlast, want.last);
                end
                results_seen++;
            end
            // A long hold-off lets the pipeline fill and stall its input.
            if (hold_served != hold_requests) begin
                hold_served = hold_requests;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Watchdog: cycles with work outstanding but no item moving on either side.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (pixel_pending.size() == 0 && sharp_owed.size() == 0 && !s_tvalid))
            wdog <= 0;
        else
            wdog <= wdog + 1;
        if (wdog >= WDOG_MAX) begin
            $display("watchdog: no progress for %0d cycles", WDOG_MAX);
            $display("FAILED: results differ");
            $finish;
        end
    end

    task automatic write_reg(input logic idx, input logic [31:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == REG_OUT_WIDTH) mir_width = value[10:0];
        else mir_height = value[11:0];
    endtask

    function automatic logic [7:0] pick_pixel(input pattern_t pat, input int r, input int c);
        case (pat)
            PAT_CHECKER: return ((r + c) % 2 == 0) ? 8'd255 : 8'd0;
            PAT_FLAT_LO: return 8'd0;
            PAT_FLAT_HI: return 8'd255;
            PAT_EXTREME: begin
                case ($urandom_range(3))
                    0: return 8'd0;
                    1: return 8'd255;
                    2: return 8'($urandom_range(3));
                    default: return 8'($urandom_range(255));
                endcase
            end
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // Set the size, send one whole padded frame and wait until it is all back.
    task automatic run_frame(input logic [31:0] wreg, input logic [31:0] hreg,
                             input pattern_t pat, input bit hold_off);
        int w, h;
        write_reg(REG_OUT_WIDTH, wreg);
        write_reg(REG_OUT_HEIGHT, hreg);
        w = eff_width() + PAD_SIZE;
        h = eff_height() + PAD_SIZE;
        case (frames_run % 3)
            0: begin send_idle_pct = 38; recv_idle_pct = 47; end
            1: begin send_idle_pct = 47; recv_idle_pct = 38; end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
        endcase
        for (int r = 0; r < h; r++)
            for (int c = 0; c < w; c++)
                pixel_pending.push_back(pick_pixel(pat, r, c));
        if (hold_off) hold_requests++;
        // The task waits until every pixel is sent and every owed result has arrived.
        while (pixel_pending.size() > 0 || s_tvalid || sharp_owed.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);
        frames_run++;
    endtask

    initial
    begin
        int start_sent;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Smallest frames and a 3x2 frame with flat, checkered and extreme content.
        run_frame(1, 1, PAT_CHECKER, 1'b0);
        run_frame(1, 1, PAT_FLAT_LO, 1'b0);
        run_frame(1, 1, PAT_FLAT_HI, 1'b0);
        run_frame(0, 0, PAT_EXTREME, 1'b0);
        run_frame(3, 2, PAT_CHECKER, 1'b1);

        // Random small frames.
        start_sent = pixels_sent;
        while (pixels_sent - start_sent < 550)
            run_frame($urandom_range(8), $urandom_range(4),
                      ($urandom_range(1) == 0) ? PAT_RANDOM : PAT_EXTREME,
                      ($urandom_range(9) == 0));

        run_frame(5, 3, PAT_RANDOM, 1'b0);

        repeat (DRAIN_CYC) @(posedge clk);
        $display("covered %0d frames, %0d pixels in, %0d results out", frames_run,
                 pixels_sent, results_seen);
        $display("small frames with zero sizes, long output stalls and random idling");
        if (mismatches == 0 && sharp_owed.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("%0d mismatches, %0d results never came", mismatches, sharp_owed.size());
            $display("FAILED: results differ");
        end
        $finish;
    end
endmodule
`default_nettype wire
